// ===== rtl/core/bitmap_block_pool_allocator_top_macros.svh =====
// Assertion helpers for the pool allocator. Define ASSERT_OFF to compile them out.
`ifndef BITMAP_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define BBPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition must never be true outside reset.
`define BBPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define BBPA_ASSERT(lbl, prop, msg)
`define BBPA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== rtl/core/bbpa_pkg.sv =====
package bbpa_pkg;

  localparam int MAX_BLOCKS = 64;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 17;
  localparam int CNT_W      = 7;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int OFF_W      = IDX_W + SIZE_W;
  localparam int LIM_W      = CNT_W + SIZE_W;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 4;

  // Free search runs in groups of eight blocks.
  localparam int GRP_BITS = 8;
  localparam int BIT_W    = $clog2(GRP_BITS);
  localparam int NGRP     = (MAX_BLOCKS + GRP_BITS - 1) / GRP_BITS;
  localparam int GRP_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int STEP_W   = (IDX_W > 1) ? $clog2(IDX_W) : 1;

  localparam logic [ADDR_W-1:0] RST_BASE       = '0;
  localparam logic [SIZE_W-1:0] RST_SIZE       = SIZE_W'(1024);
  localparam logic [CNT_W-1:0]  RST_BLOCKS     = CNT_W'(8);
  localparam logic [CNT_W-1:0]  RST_FREE_COUNT = CNT_W'(8);

  typedef enum logic [1:0] {
    REG_BASE   = 2'd0,
    REG_SIZE   = 2'd1,
    REG_BLOCKS = 2'd2
  } bbpa_reg_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } bbpa_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } bbpa_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_MUL,
    S_FIN_ALLOC,
    S_CHECK,
    S_RANGE,
    S_DIV,
    S_FIN_FREE
  } bbpa_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] bsz;
    logic [CNT_W-1:0]  nblk;
    logic              reinit;
  } bbpa_cfg_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic mul;
    logic fin_alloc;
    logic check;
    logic div_init;
    logic div_step;
    logic fin_free;
  } bbpa_cmd_t;

  typedef struct packed {
    logic out_range;
    logic div_last;
  } bbpa_stat_t;

endpackage

// ===== rtl/core/bitmap_block_pool_allocator_top.sv =====
// Fixed-size block pool allocator with a free bitmap and a free count.
// Requests: drive op_i (0 allocate, 1 free) and free_address_i with start;
// a request is taken on a rising edge with start high and busy low.
// Results: done_o is high for one cycle with status_o, block_address_o,
// block_index_o and free_blocks_left_o; the receiver cannot hold them off,
// so capture them in that cycle.
// Steps from the accepting edge to the done cycle:
//   allocate                two-step group search, multiply, commit
//   free, address in pool   range check, divide (six quotient bits), commit
//   free, address outside   range check, commit
// busy drops in the done cycle, so a new request may follow at once; one
// request is in flight at a time.
// Configuration: APB-style port, pool base at 0x0, block size at 0x4, block
// count at 0x8. Writing the count marks every block free. Write only when idle.
// Reset: base 0, block size 1024, 8 blocks, all free; no result is pending.
`include "bitmap_block_pool_allocator_top_macros.svh"

module bitmap_block_pool_allocator_top import bbpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               op_i,
  input  logic [ADDR_W-1:0]  free_address_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [ADDR_W-1:0]  block_address_o,
  output logic [IDX_W-1:0]   block_index_o,
  output logic [CNT_W-1:0]   free_blocks_left_o
);

  bbpa_cfg_t  cfg;
  bbpa_cmd_t  cmd;
  bbpa_stat_t stat;

  bbpa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bbpa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .op_i   (op_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  bbpa_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .free_address_i     (free_address_i),
    .stat_o             (stat),
    .status_o           (status_o),
    .block_address_o    (block_address_o),
    .block_index_o      (block_index_o),
    .free_blocks_left_o (free_blocks_left_o)
  );

  `BBPA_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request left busy low")
  `BBPA_ASSERT(a_done_idle, done_o |-> !busy, "result word shown while still busy")
  `BBPA_ASSERT_NEVER(a_done_pulse, done_o && $past(done_o), "result word held past one cycle")
  `BBPA_ASSERT(a_empty_count, (done_o && status_o == ST_EMPTY) |-> (free_blocks_left_o == '0), "pool empty with free blocks counted")
  `BBPA_ASSERT(a_fail_addr, (done_o && status_o != ST_OK) |-> (block_address_o == '0), "failed request returned an address")

endmodule

// ===== rtl/core/bbpa_cfg.sv =====
module bbpa_cfg import bbpa_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready,
  output bbpa_cfg_t          cfg_o
);

  logic [ADDR_W-1:0] base_q;
  logic [SIZE_W-1:0] size_q;
  logic [CNT_W-1:0]  blocks_q;
  logic              reinit_q;
  logic              wr_en;
  bbpa_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = bbpa_reg_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= RST_BASE;
      size_q   <= RST_SIZE;
      blocks_q <= RST_BLOCKS;
      reinit_q <= 1'b0;
    end else begin
      reinit_q <= 1'b0;
      if (wr_en) begin
        case (reg_sel)
          REG_BASE: begin
            base_q <= pwdata[ADDR_W-1:0];
          end
          REG_SIZE: begin
            size_q <= pwdata[SIZE_W-1:0];
          end
          REG_BLOCKS: begin
            blocks_q <= pwdata[CNT_W-1:0];
            reinit_q <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    case (reg_sel)
      REG_BASE:   prdata = DATA_W'(base_q);
      REG_SIZE:   prdata = DATA_W'(size_q);
      REG_BLOCKS: prdata = DATA_W'(blocks_q);
      default:    prdata = '0;
    endcase
  end

  // Clamp the count to capacity and treat a zero size as one byte.
  assign cfg_o.base   = base_q;
  assign cfg_o.bsz    = (size_q == '0) ? SIZE_W'(1) : size_q;
  assign cfg_o.nblk   = (blocks_q > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : blocks_q;
  assign cfg_o.reinit = reinit_q;

endmodule

// ===== rtl/core/bbpa_ctrl.sv =====
module bbpa_ctrl import bbpa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic       op_i,
  input  bbpa_stat_t stat_i,
  output bbpa_cmd_t  cmd_o,
  output logic       busy,
  output logic       done_o
);

  bbpa_state_e state_q, state_d;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == S_FIN_ALLOC) || (state_q == S_FIN_FREE);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = (op_i == OP_FREE) ? S_CHECK : S_SCAN;
        end
      end
      S_SCAN:      state_d = S_PICK;
      S_PICK:      state_d = S_MUL;
      S_MUL:       state_d = S_FIN_ALLOC;
      S_FIN_ALLOC: state_d = S_IDLE;
      S_CHECK:     state_d = S_RANGE;
      S_RANGE:     state_d = stat_i.out_range ? S_FIN_FREE : S_DIV;
      S_DIV:       state_d = stat_i.div_last ? S_FIN_FREE : S_DIV;
      S_FIN_FREE:  state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_IDLE:      cmd_o.load      = start;
      S_SCAN:      cmd_o.scan      = 1'b1;
      S_PICK:      cmd_o.pick      = 1'b1;
      S_MUL:       cmd_o.mul       = 1'b1;
      S_FIN_ALLOC: cmd_o.fin_alloc = 1'b1;
      S_CHECK:     cmd_o.check     = 1'b1;
      S_RANGE:     cmd_o.div_init  = 1'b1;
      S_DIV:       cmd_o.div_step  = 1'b1;
      S_FIN_FREE:  cmd_o.fin_free  = 1'b1;
      default: begin
      end
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

// ===== rtl/core/bbpa_dp.sv =====
module bbpa_dp import bbpa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bbpa_cmd_t         cmd_i,
  input  bbpa_cfg_t         cfg_i,
  input  logic [ADDR_W-1:0] free_address_i,
  output bbpa_stat_t        stat_o,
  output logic [1:0]        status_o,
  output logic [ADDR_W-1:0] block_address_o,
  output logic [IDX_W-1:0]  block_index_o,
  output logic [CNT_W-1:0]  free_blocks_left_o
);

  logic [MAX_BLOCKS-1:0]     map_q;
  logic [CNT_W-1:0]          count_q;

  logic [ADDR_W-1:0]         addr_q;
  logic [GRP_W-1:0]          grp_q;
  logic [GRP_BITS-1:0]       byte_q;
  logic                      found_q;
  logic [IDX_W-1:0]          idx_q;
  logic [OFF_W-1:0]          prod_q;
  logic [ADDR_W-1:0]         off_q;
  logic                      below_q;
  logic [LIM_W-1:0]          lim_q;
  logic                      range_q;
  logic [OFF_W-1:0]          rem_q;
  logic [OFF_W-1:0]          dvs_q;
  logic [IDX_W-1:0]          quo_q;
  logic [STEP_W-1:0]         step_q;
  bbpa_status_e              status_q;
  logic [ADDR_W-1:0]         baddr_q;
  logic [IDX_W-1:0]          bidx_q;

  logic [MAX_BLOCKS-1:0]     masked;
  logic [NGRP*GRP_BITS-1:0]  padded;
  logic [NGRP-1:0]           grp_any;
  logic [GRP_W-1:0]          grp_sel;
  logic [BIT_W-1:0]          bit_sel;
  logic [OFF_W-1:0]          prod;
  logic [LIM_W-1:0]          lim;
  logic [ADDR_W:0]           diff;
  logic [OFF_W:0]            trial;
  logic                      take;
  logic                      out_range;

  // Only blocks below the effective count take part in the search.
  always_comb begin
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      masked[i] = map_q[i] & (CNT_W'(i) < cfg_i.nblk);
    end
  end

  assign padded = (NGRP*GRP_BITS)'(masked);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any[g] = |padded[g*GRP_BITS +: GRP_BITS];
    end
  end

  // Lowest group holding a free block wins.
  always_comb begin
    grp_sel = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = GRP_W'(g);
      end
    end
  end

  always_comb begin
    bit_sel = '0;
    for (int b = GRP_BITS - 1; b >= 0; b--) begin
      if (byte_q[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
  end

  assign prod      = OFF_W'(idx_q) * OFF_W'(cfg_i.bsz);
  assign lim       = LIM_W'(cfg_i.nblk) * LIM_W'(cfg_i.bsz);
  assign diff      = {1'b0, addr_q} - {1'b0, cfg_i.base};
  assign out_range = below_q || (off_q >= ADDR_W'(lim_q));
  assign trial     = {1'b0, rem_q} - {1'b0, dvs_q};
  assign take      = ~trial[OFF_W];

  assign stat_o.out_range = out_range;
  assign stat_o.div_last  = (step_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '1;
      count_q <= RST_FREE_COUNT;
    end else if (cfg_i.reinit) begin
      map_q   <= '1;
      count_q <= cfg_i.nblk;
    end else if (cmd_i.fin_alloc) begin
      if (found_q) begin
        map_q[idx_q] <= 1'b0;
        if (count_q != '0) begin
          count_q <= count_q - CNT_W'(1);
        end
      end
    end else if (cmd_i.fin_free) begin
      if (!range_q && !map_q[quo_q]) begin
        map_q[quo_q] <= 1'b1;
        if (count_q < cfg_i.nblk) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= free_address_i;
    end
    if (cmd_i.scan) begin
      grp_q   <= grp_sel;
      byte_q  <= padded[grp_sel*GRP_BITS +: GRP_BITS];
      found_q <= |grp_any;
    end
    if (cmd_i.pick) begin
      idx_q <= IDX_W'({grp_q, bit_sel});
    end
    if (cmd_i.mul) begin
      prod_q <= prod;
    end
    if (cmd_i.check) begin
      off_q   <= diff[ADDR_W-1:0];
      below_q <= diff[ADDR_W];
      lim_q   <= lim;
    end
    // Offset is below count times size, so the quotient needs IDX_W bits.
    if (cmd_i.div_init) begin
      range_q <= out_range;
      rem_q   <= off_q[OFF_W-1:0];
      dvs_q   <= OFF_W'(cfg_i.bsz) << (IDX_W - 1);
      quo_q   <= '0;
      step_q  <= STEP_W'(IDX_W - 1);
    end
    if (cmd_i.div_step) begin
      if (take) begin
        rem_q <= trial[OFF_W-1:0];
      end
      quo_q  <= {quo_q[IDX_W-2:0], take};
      dvs_q  <= dvs_q >> 1;
      step_q <= step_q - STEP_W'(1);
    end
    if (cmd_i.fin_alloc) begin
      if (found_q) begin
        status_q <= ST_OK;
        baddr_q  <= cfg_i.base + ADDR_W'(prod_q);
        bidx_q   <= idx_q;
      end else begin
        status_q <= ST_EMPTY;
        baddr_q  <= '0;
        bidx_q   <= '0;
      end
    end
    if (cmd_i.fin_free) begin
      baddr_q <= '0;
      if (range_q) begin
        status_q <= ST_RANGE;
        bidx_q   <= '0;
      end else begin
        status_q <= map_q[quo_q] ? ST_DOUBLE : ST_OK;
        bidx_q   <= quo_q;
      end
    end
  end

  assign status_o           = status_q;
  assign block_address_o    = baddr_q;
  assign block_index_o      = bidx_q;
  assign free_blocks_left_o = count_q;

endmodule
